### rtl/rgb_to_palette_indexer_unit_defines.svh
// Assertion macros for the palette indexer checker.
// Depends on a clock named clk and a reset named rst in the using scope.
`ifndef RGB_TO_PALETTE_INDEXER_UNIT_DEFINES_SVH
`define RGB_TO_PALETTE_INDEXER_UNIT_DEFINES_SVH

// same-cycle implication, off while in reset
`define RTPI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtpi check failed");

// next-cycle implication, off while in reset
`define RTPI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtpi check failed");

`endif

### rtl/rtpi_pkg.sv
// Shared constants, types and helpers for the palette indexer.
// No dependencies.
`default_nettype none
package rtpi_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int COLOUR_W      = 24;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 2;

  localparam logic [1:0] FMT_16 = 2'd0;
  localparam logic [1:0] FMT_24 = 2'd1;
  localparam logic [1:0] FMT_32 = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_RED     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_GREEN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_BLUE    = 2'd3;

  localparam logic [7:0] DEFAULT_FIELD_MASK = 8'h1F;
  localparam int         RED_SHIFT          = 10;
  localparam int         GREEN_SHIFT        = 5;

  typedef logic [COLOUR_W-1:0] colour_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    colour_t           wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [7:0] colour_index;
    logic       was_new;
    logic       palette_full;
  } res_t;

  function automatic logic [7:0] index_byte(input logic [CNT_W-1:0] v);
    logic [CNT_W+7:0] ext;
    ext = {8'd0, v};
    return ext[7:0];
  endfunction

endpackage
`default_nettype wire

### rtl/rtpi_decode.sv
// Configuration registers and pixel word to 24-bit colour extraction.
// Depends on rtpi_pkg.
`default_nettype none
module rtpi_decode import rtpi_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic [31:0]          pixel_word,
  output colour_t                   colour
);

  logic [1:0]       pixel_format;
  logic [CFG_W-1:0] mask_red;
  logic [CFG_W-1:0] mask_green;
  logic [CFG_W-1:0] mask_blue;

  logic [15:0] p;
  logic [15:0] r_sh;
  logic [15:0] g_sh;
  logic [7:0]  r_mask;
  logic [7:0]  g_mask;
  logic [7:0]  b_mask;
  logic        use_masks;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_32;
      mask_red     <= '0;
      mask_green   <= '0;
      mask_blue    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIXEL_FORMAT: pixel_format <= cfg_data[1:0];
        REG_MASK_RED:     mask_red     <= cfg_data;
        REG_MASK_GREEN:   mask_green   <= cfg_data;
        REG_MASK_BLUE:    mask_blue    <= cfg_data;
        default:          pixel_format <= pixel_format;
      endcase
    end
  end

  always_comb begin
    p         = pixel_word[15:0];
    r_sh      = p >> RED_SHIFT;
    g_sh      = p >> GREEN_SHIFT;
    use_masks = (mask_red != '0);
    r_mask    = use_masks ? mask_red[7:0]   : DEFAULT_FIELD_MASK;
    g_mask    = use_masks ? mask_green[7:0] : DEFAULT_FIELD_MASK;
    b_mask    = use_masks ? mask_blue[7:0]  : DEFAULT_FIELD_MASK;
    if (pixel_format == FMT_16) begin
      colour = {p[7:0] & b_mask, g_sh[7:0] & g_mask, r_sh[7:0] & r_mask};
    end else begin
      colour = pixel_word[23:0];
    end
  end

endmodule
`default_nettype wire

### rtl/rtpi_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none
module rtpi_ram #(
  parameter int DATA_W = 24,
  parameter int ADDR_W = 8,
  parameter int DEPTH  = 1 << ADDR_W
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/rtpi_search.sv
// Palette search sequencer: streams reads over the valid entries, compares
// one entry per cycle and appends a missing colour while there is room. Depends on rtpi_pkg.
`default_nettype none
module rtpi_search import rtpi_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire logic    new_image,
  input  wire colour_t colour_in,
  input  wire colour_t rd_data,
  output ram_req_t     ram_req,
  output logic         busy,
  output logic         done,
  output res_t         result
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PALETTE_DEPTH);

  logic              state;
  colour_t           colour;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  ptr;
  logic              cmp_valid;
  logic [ADDR_W-1:0] cmp_idx;

  logic hit;
  logic issue;
  logic room;

  assign busy  = (state == ST_SEARCH);
  assign hit   = busy && cmp_valid && (rd_data == colour);
  assign issue = busy && !hit && (ptr < count);
  assign room  = (count < DEPTH_CNT);

  always_comb begin
    ram_req.re    = issue;
    ram_req.raddr = ptr[ADDR_W-1:0];
    ram_req.we    = busy && !hit && !issue && room;
    ram_req.waddr = count[ADDR_W-1:0];
    ram_req.wdata = colour;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      count     <= '0;
      cmp_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (new_image) begin
              count <= '0;
            end
            cmp_valid <= 1'b0;
            state     <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (hit) begin
            cmp_valid <= 1'b0;
            done      <= 1'b1;
            state     <= ST_IDLE;
          end else if (issue) begin
            cmp_valid <= 1'b1;
          end else begin
            cmp_valid <= 1'b0;
            if (room) begin
              count <= count + CNT_W'(1);
            end
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && start) begin
      colour <= colour_in;
      ptr    <= '0;
    end else if (issue) begin
      ptr     <= ptr + CNT_W'(1);
      cmp_idx <= ptr[ADDR_W-1:0];
    end
    if (hit) begin
      result.colour_index <= index_byte(CNT_W'(cmp_idx));
      result.was_new      <= 1'b0;
      result.palette_full <= 1'b0;
    end else if (busy && !issue) begin
      result.colour_index <= room ? index_byte(count) : 8'd0;
      result.was_new      <= room;
      result.palette_full <= !room;
    end
  end

endmodule
`default_nettype wire

### rtl/rgb_to_palette_indexer_unit.sv
// Top level of the palette indexer: decode, search sequencer and palette RAM.
// Depends on rtpi_pkg, rtpi_decode, rtpi_search and rtpi_ram.
//
//   channel   handshake            payload
//   -------   ------------------   ----------------------------------------
//   input     start / busy         pixel_word, new_image
//   result    done (one cycle)     colour_index, was_new, palette_full
//   config    cfg_we               cfg_index, cfg_data
//
// A colour is compared against the filled palette entries in index order, one
// entry per cycle; a search ends at the first match or, with no match, appends
// the colour at the fill count when there is room.
// A new transaction can be accepted in the cycle that done is high.
// Synchronous reset empties the palette by clearing the fill count.
// The receiver takes every result; there is no result stall.
`default_nettype none
module rgb_to_palette_indexer_unit import rtpi_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [31:0]          pixel_word,
  input  wire logic                 new_image,
  output logic                      done,
  output logic [7:0]                colour_index,
  output logic                      was_new,
  output logic                      palette_full,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  colour_t  colour;
  colour_t  rd_data;
  ram_req_t ram_req;
  res_t     result;

  rtpi_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_word (pixel_word),
    .colour     (colour)
  );

  rtpi_search u_search (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .new_image (new_image),
    .colour_in (colour),
    .rd_data   (rd_data),
    .ram_req   (ram_req),
    .busy      (busy),
    .done      (done),
    .result    (result)
  );

  rtpi_ram #(
    .DATA_W (COLOUR_W),
    .ADDR_W (ADDR_W),
    .DEPTH  (PALETTE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  assign colour_index = result.colour_index;
  assign was_new      = result.was_new;
  assign palette_full = result.palette_full;

endmodule
`default_nettype wire

### rtl/rtpi_checker.sv
// Port-level checks for the palette indexer, bound to the top level.
// Depends on rgb_to_palette_indexer_unit_defines.svh.
`default_nettype none
`include "rgb_to_palette_indexer_unit_defines.svh"
module rtpi_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [7:0] colour_index,
  input wire logic       was_new,
  input wire logic       palette_full
);

  `RTPI_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `RTPI_ASSERT_IMP(a_done_idle, done, !busy)
  `RTPI_ASSERT_IMP(a_flags_excl, done, !(was_new && palette_full))
  `RTPI_ASSERT_IMP(a_full_zero, done && palette_full, colour_index == 8'd0)

endmodule

bind rgb_to_palette_indexer_unit rtpi_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .colour_index (colour_index),
  .was_new      (was_new),
  .palette_full (palette_full)
);
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for rgb_to_palette_indexer_unit: pixel words go through a queued driver,
// and a scoreboard checks every index against a palette predictor. Depends on rtpi_pkg.
module tb_top;
  import rtpi_pkg::*;

  localparam logic [1:0] FMT_SPARE = 2'd3;

  typedef struct {
    logic [31:0] word;
    logic        fresh;
    int unsigned idle;
    bit          hold;
  } pixel_txn_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [31:0]          pixel_word = '0;
  logic                 new_image = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 busy;
  logic                 done;
  logic [7:0]           colour_index;
  logic                 was_new;
  logic                 palette_full;

  rgb_to_palette_indexer_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel_word(pixel_word), .new_image(new_image),
    .done(done), .colour_index(colour_index), .was_new(was_new),
    .palette_full(palette_full),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pixel_txn_t  pixel_queue[$];
  res_t        index_queue[$];
  colour_t     seen_colours[PALETTE_DEPTH];
  int unsigned colour_count = 0;
  logic [1:0]  fmt_shadow = FMT_32;
  logic [15:0] mask_r = '0;
  logic [15:0] mask_g = '0;
  logic [15:0] mask_b = '0;

  int unsigned issued = 0;
  int unsigned seen = 0;
  int unsigned gap_left = 0;
  bit          gap_armed = 0;
  int unsigned burst_left = 0;
  bit          hold_next = 0;
  int unsigned mismatches = 0;
  int unsigned n_results = 0;
  int unsigned n_new = 0;
  int unsigned n_full = 0;
  int unsigned n_settings = 1;

  function automatic res_t index_pixel(input logic [31:0] w, input logic fresh);
    colour_t     c;
    res_t        r;
    int unsigned hit;
    logic [15:0] p, rc, gc, bc;
    if (fresh) colour_count = 0;
    if (fmt_shadow == FMT_16) begin
      p = w[15:0];
      if (mask_r != '0) begin
        rc = (p >> RED_SHIFT) & mask_r;
        gc = (p >> GREEN_SHIFT) & mask_g;
        bc = p & mask_b;
      end else begin
        rc = (p >> RED_SHIFT) & {8'h00, DEFAULT_FIELD_MASK};
        gc = (p >> GREEN_SHIFT) & {8'h00, DEFAULT_FIELD_MASK};
        bc = p & {8'h00, DEFAULT_FIELD_MASK};
      end
      c = {bc[7:0], gc[7:0], rc[7:0]};
    end else begin
      c = w[23:0];
    end
    r = '0;
    hit = colour_count;
    for (int unsigned i = 0; i < colour_count; i++) begin
      if (seen_colours[i] == c) begin
        hit = i;
        break;
      end
    end
    if (hit < colour_count) begin
      r.colour_index = 8'(hit);
    end else if (colour_count < PALETTE_DEPTH) begin
      seen_colours[colour_count] = c;
      r.colour_index = 8'(colour_count);
      r.was_new = 1'b1;
      colour_count++;
    end else begin
      r.palette_full = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin : drive
    pixel_txn_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (done) seen++;
      if (start && !busy) begin
        index_queue = {index_queue, index_pixel(pixel_word, new_image)};
        issued++;
      end
      if (!start || !busy) begin
        if (pixel_queue.size() == 0) begin
          start <= 1'b0;
        end else begin
          if (!gap_armed) begin
            gap_left = pixel_queue[0].idle;
            gap_armed = 1;
          end
          if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
          end else if (pixel_queue[0].hold && issued != seen) begin
            start <= 1'b0;
          end else begin
            nxt = pixel_queue.pop_front();
            start <= 1'b1;
            pixel_word <= nxt.word;
            new_image <= nxt.fresh;
            gap_armed = 0;
          end
        end
      end
    end
  end

  always @(posedge clk) begin : check
    res_t want;
    if (!rst && done) begin
      n_results++;
      if (was_new === 1'b1) n_new++;
      if (palette_full === 1'b1) n_full++;
      if (index_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result index=%0d new=%b full=%b", $realtime,
                   colour_index, was_new, palette_full);
      end else begin
        want = index_queue.pop_front();
        if (colour_index !== want.colour_index || was_new !== want.was_new ||
            palette_full !== want.palette_full) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch index=%0d/%0d new=%b/%b full=%b/%b (exp/act)",
                     $realtime, want.colour_index, colour_index, want.was_new, was_new,
                     want.palette_full, palette_full);
        end
      end
    end
  end

  task automatic add_pixel(input logic [31:0] w, input logic fresh);
    pixel_txn_t  t;
    int unsigned roll;
    t.word = w;
    t.fresh = fresh;
    t.hold = hold_next || ($urandom_range(99) == 0);
    hold_next = 0;
    roll = $urandom_range(99);
    if (burst_left > 0) begin
      burst_left--;
      t.idle = 0;
    end else if (roll < 4) begin
      burst_left = $urandom_range(60, 15);
      t.idle = 0;
    end else if (roll < 50) begin
      t.idle = 0;
    end else if (roll < 88) begin
      t.idle = $urandom_range(3, 1);
    end else begin
      t.idle = $urandom_range(60, 4);
    end
    pixel_queue = {pixel_queue, t};
  endtask

  task automatic gen_image(input int unsigned len, input int unsigned reuse_pct,
                           input bit fresh);
    logic [31:0] used[$];
    logic [31:0] w;
    logic [31:0] junk;
    int unsigned roll;
    for (int unsigned i = 0; i < len; i++) begin
      junk = $urandom;
      roll = $urandom_range(99);
      if (used.size() != 0 && roll < reuse_pct) begin
        w = used[$urandom_range(used.size() - 1)];
        if (fmt_shadow == FMT_16) w = w ^ {junk[15:0], 16'h0000};
        else w = w ^ {junk[7:0], 24'h000000};
      end else begin
        if (roll % 20 == 0) w = 32'h0000_0000;
        else if (roll % 20 == 1) w = 32'hFFFF_FFFF;
        else w = $urandom;
        used = {used, w};
      end
      add_pixel(w, (i == 0) ? fresh : ($urandom_range(199) == 0));
    end
  endtask

  task automatic fill_phase(input int unsigned budget);
    int unsigned n;
    int unsigned len;
    n = 0;
    while (n < budget) begin
      len = $urandom_range(40, 1);
      gen_image(len, $urandom_range(70, 20), $urandom_range(9) != 0);
      n += len;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || start || issued != seen);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_PIXEL_FORMAT: fmt_shadow = val[1:0];
      REG_MASK_RED:     mask_r = val;
      REG_MASK_GREEN:   mask_g = val;
      default:          mask_b = val;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    n_settings++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: 32-bit words
    add_pixel(32'h0000_0000, 1'b1);
    add_pixel(32'hFFFF_FFFF, 1'b0);
    add_pixel(32'hFF00_0000, 1'b0);
    add_pixel(32'h00FF_FFFF, 1'b0);
    add_pixel(32'h00AA_55CC, 1'b0);
    add_pixel(32'h00AA_55CC, 1'b1);
    hold_next = 1;
    add_pixel(32'h0000_0001, 1'b0);
    fill_phase(140);
    wait_idle();

    write_reg(REG_PIXEL_FORMAT, {14'($urandom), FMT_24});
    end_writes();
    gen_image(330, 20, 1'b1);
    fill_phase(80);
    wait_idle();

    // 16-bit default fields; green and blue masks must not matter
    write_reg(REG_PIXEL_FORMAT, {14'($urandom), FMT_16});
    write_reg(REG_MASK_RED, 16'h0000);
    write_reg(REG_MASK_GREEN, 16'hFFFF);
    write_reg(REG_MASK_BLUE, 16'hFFFF);
    end_writes();
    add_pixel(32'h0000_FFFF, 1'b1);
    add_pixel(32'h0000_7FFF, 1'b0);
    add_pixel(32'hFFFF_0000, 1'b0);
    add_pixel(32'h0000_0000, 1'b0);
    add_pixel(32'h0000_7C00, 1'b0);
    add_pixel(32'h0000_03E0, 1'b0);
    add_pixel(32'h0000_001F, 1'b0);
    gen_image(300, 20, 1'b1);
    fill_phase(60);
    wait_idle();

    write_reg(REG_MASK_RED, 16'hFFFF);
    end_writes();
    add_pixel(32'h0000_FFFF, 1'b1);
    add_pixel(32'h0000_7FFF, 1'b0);
    add_pixel(32'h0000_03FF, 1'b0);
    add_pixel(32'h0000_FC00, 1'b0);
    fill_phase(120);
    wait_idle();

    write_reg(REG_MASK_RED, 16'($urandom_range(16'hFFFF, 1)));
    write_reg(REG_MASK_GREEN, 16'($urandom));
    write_reg(REG_MASK_BLUE, 16'($urandom));
    end_writes();
    fill_phase(150);
    wait_idle();

    // spare format code decodes as 32-bit; keep the palette across the change
    write_reg(REG_PIXEL_FORMAT, {14'($urandom), FMT_SPARE});
    end_writes();
    add_pixel(32'h1234_5678, 1'b0);
    add_pixel(32'h8734_5678, 1'b0);
    gen_image(120, 40, 1'b0);
    wait_idle();

    write_reg(REG_PIXEL_FORMAT, {14'($urandom), FMT_16});
    write_reg(REG_MASK_RED, 16'h0001);
    write_reg(REG_MASK_GREEN, 16'h0000);
    write_reg(REG_MASK_BLUE, 16'h0000);
    end_writes();
    fill_phase(60);
    wait_idle();

    write_reg(REG_PIXEL_FORMAT, {14'($urandom), FMT_32});
    write_reg(REG_MASK_RED, 16'hFFFF);
    write_reg(REG_MASK_GREEN, 16'hFFFF);
    write_reg(REG_MASK_BLUE, 16'hFFFF);
    end_writes();
    fill_phase(60);
    wait_idle();

    repeat (PALETTE_DEPTH + 4) @(negedge clk);
    if (index_queue.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", index_queue.size());
    end
    $display("Checked %0d pixel transactions over %0d register settings:", n_results,
             n_settings);
    $display("  %0d new colours, %0d palette hits, %0d overflows", n_new,
             n_results - n_new - n_full, n_full);
    if (mismatches == 0) begin
      $display("rgb_to_palette_indexer_unit verification clean");
    end else begin
      $display("rgb_to_palette_indexer_unit verification failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Timeout after %0d results", n_results);
    $display("rgb_to_palette_indexer_unit verification failed");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/rtpi_pkg.sv
rtl/rtpi_decode.sv
rtl/rtpi_ram.sv
rtl/rtpi_search.sv
rtl/rgb_to_palette_indexer_unit.sv
rtl/rtpi_checker.sv
sim/tb_top.sv
